FILE: src/ptcp_pkg.sv
// ----------------------------------------------------------------------------
// ptcp_pkg: shared types and constants for the closest point unit
// Status codes, the control record and the width and latency helpers used by
// the front, queue and back.
// ----------------------------------------------------------------------------
package ptcp_pkg;

    // width of every coordinate port and of the distance port
    localparam int FIELD_BITS  = 32;
    localparam int DIST_BITS   = 64;
    localparam int STATUS_BITS = 2;

    // operand chunk of one partial product in the pipelined multiplier
    localparam int MUL_CHUNK = 34;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

    typedef enum logic [STATUS_BITS-1:0] {
        ST_FOUND   = 2'd0,
        ST_DEGEN   = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_ctl;

    // edge and offset width
    function automatic int ew_bits(int c);
        return c + 1;
    endfunction

    // dot product width
    function automatic int dw_bits(int c);
        return 2 * ew_bits(c) + 2;
    endfunction

    // determinant and numerator width
    function automatic int tw_bits(int c);
        return 2 * dw_bits(c) + 1;
    endfunction

    // bits of one classified item: det, nu, nv, e0, e1, corner2, query
    function automatic int item_bits(int c);
        return 3 * tw_bits(c) + 6 * ew_bits(c) + 6 * c;
    endfunction

    // cycles through one pipelined multiplier
    function automatic int mul_lat(int aw, int bw);
        return ((aw + MUL_CHUNK - 1) / MUL_CHUNK) * ((bw + MUL_CHUNK - 1) / MUL_CHUNK) + 2;
    endfunction

endpackage

FILE: src/ptcp_mul.sv
// ----------------------------------------------------------------------------
// ptcp_mul: pipelined signed multiplier
// Sign and magnitude split, one chunk partial product accumulated per stage,
// sign restored in the last stage.
// ----------------------------------------------------------------------------
module ptcp_mul import ptcp_pkg::*; #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                  i_clk,
    input  logic signed [AW-1:0]  i_a,
    input  logic signed [BW-1:0]  i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NS = NA * NB;
    localparam int PW = AW + BW;
    localparam int XA = NA * MUL_CHUNK;
    localparam int XB = NB * MUL_CHUNK;

    logic [XA-1:0] r_ma  [0:NS];
    logic [XB-1:0] r_mb  [0:NS];
    logic          r_sg  [0:NS];
    logic [PW-1:0] r_acc [0:NS];
    logic [PW-1:0] r_p;

    logic [AW-1:0] w_ma;
    logic [BW-1:0] w_mb;

    // split into sign and magnitude
    assign w_ma = i_a[AW-1] ? AW'(~i_a + 1'b1) : AW'(i_a);
    assign w_mb = i_b[BW-1] ? BW'(~i_b + 1'b1) : BW'(i_b);

    always_ff @(posedge i_clk) begin
        r_ma[0]  <= XA'(w_ma);
        r_mb[0]  <= XB'(w_mb);
        r_sg[0]  <= i_a[AW-1] ^ i_b[BW-1];
        r_acc[0] <= '0;
    end

    // accumulate one partial product per stage
    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int I = k / NB;
        localparam int J = k % NB;
        logic [2*MUL_CHUNK-1:0] w_pp;
        logic [XA+XB-1:0]       w_sh;

        assign w_pp = r_ma[k][I*MUL_CHUNK +: MUL_CHUNK] * r_mb[k][J*MUL_CHUNK +: MUL_CHUNK];
        assign w_sh = (XA + XB)'(w_pp) << (MUL_CHUNK * (I + J));

        always_ff @(posedge i_clk) begin
            r_ma[k+1]  <= r_ma[k];
            r_mb[k+1]  <= r_mb[k];
            r_sg[k+1]  <= r_sg[k];
            r_acc[k+1] <= r_acc[k] + w_sh[PW-1:0];
        end
    end

    // restore the sign
    always_ff @(posedge i_clk) begin
        r_p <= r_sg[NS] ? PW'(~r_acc[NS] + 1'b1) : r_acc[NS];
    end

    assign o_p = signed'(r_p);

endmodule

FILE: src/ptcp_dly.sv
// ----------------------------------------------------------------------------
// ptcp_dly: fixed delay line
// Carries side data and valid flags alongside the arithmetic pipelines.
// ----------------------------------------------------------------------------
module ptcp_dly import ptcp_pkg::*; #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_d [0:N-1];

    // advance one tap per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N; s++) r_d[s] <= '0;
        end else begin
            for (int s = N - 1; s > 0; s--) r_d[s] <= r_d[s-1];
            r_d[0] <= i_d;
        end
    end

    assign o_d = r_d[N-1];

endmodule

FILE: src/ptcp_front.sv
// ----------------------------------------------------------------------------
// ptcp_front: accept and classify
// Forms edges, dot products and the Cramer terms det, nu, nv, then marks each
// item found, degenerate or outside.
// ----------------------------------------------------------------------------
module ptcp_front import ptcp_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_take,
    input  logic [11:0][FIELD_BITS-1:0]         i_fields,
    output t_ctl                                o_ctl,
    output logic [item_bits(COORD_BITS)-1:0]    o_data
);
    localparam int C  = COORD_BITS;
    localparam int EW = ew_bits(C);
    localparam int DW = dw_bits(C);
    localparam int TW = tw_bits(C);
    localparam int L1 = mul_lat(EW, EW);
    localparam int L2 = mul_lat(DW, DW);
    localparam int LS = L1 + L2 + 3;
    localparam int SW = 6 * EW + 6 * C;

    logic                 r_v0;
    logic signed [C-1:0]  r_c2 [3];
    logic signed [C-1:0]  r_q  [3];
    logic signed [EW-1:0] r_e0 [3];
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_dq [3];

    logic signed [2*EW-1:0] w_pa [3];
    logic signed [2*EW-1:0] w_pb [3];
    logic signed [2*EW-1:0] w_pc [3];
    logic signed [2*EW-1:0] w_pp [3];
    logic signed [2*EW-1:0] w_pr [3];

    logic signed [DW-1:0] r_a, r_b, r_c, r_p, r_r;
    logic signed [2*DW-1:0] w_ac, w_bb, w_pcx, w_br, w_ar, w_bp;
    logic signed [TW-1:0] r_det, r_nu, r_nv;
    logic signed [TW-1:0] r_detc, r_nuc, r_nvc;
    logic signed [TW+1:0] w_slack;
    t_status              w_st, r_st;

    logic [SW-1:0] w_side, w_side_d;
    logic          w_v_d;

    // capture the item and form edges from corner 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= i_take;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_c2[k] <= signed'(i_fields[6+k][C-1:0]);
            r_q[k]  <= signed'(i_fields[9+k][C-1:0]);
            r_e0[k] <= EW'(signed'(i_fields[k][C-1:0]))   - EW'(signed'(i_fields[6+k][C-1:0]));
            r_e1[k] <= EW'(signed'(i_fields[3+k][C-1:0])) - EW'(signed'(i_fields[6+k][C-1:0]));
            r_dq[k] <= EW'(signed'(i_fields[9+k][C-1:0])) - EW'(signed'(i_fields[6+k][C-1:0]));
        end
    end

    // per-axis products of the dot products
    for (genvar gk = 0; gk < 3; gk++) begin : g_dot
        ptcp_mul #(.AW(EW), .BW(EW)) u_ma (.i_clk, .i_a(r_e0[gk]), .i_b(r_e0[gk]), .o_p(w_pa[gk]));
        ptcp_mul #(.AW(EW), .BW(EW)) u_mb (.i_clk, .i_a(r_e0[gk]), .i_b(r_e1[gk]), .o_p(w_pb[gk]));
        ptcp_mul #(.AW(EW), .BW(EW)) u_mc (.i_clk, .i_a(r_e1[gk]), .i_b(r_e1[gk]), .o_p(w_pc[gk]));
        ptcp_mul #(.AW(EW), .BW(EW)) u_mp (.i_clk, .i_a(r_dq[gk]), .i_b(r_e0[gk]), .o_p(w_pp[gk]));
        ptcp_mul #(.AW(EW), .BW(EW)) u_mr (.i_clk, .i_a(r_dq[gk]), .i_b(r_e1[gk]), .o_p(w_pr[gk]));
    end

    // sum the axes
    always_ff @(posedge i_clk) begin
        r_a <= DW'(w_pa[0]) + DW'(w_pa[1]) + DW'(w_pa[2]);
        r_b <= DW'(w_pb[0]) + DW'(w_pb[1]) + DW'(w_pb[2]);
        r_c <= DW'(w_pc[0]) + DW'(w_pc[1]) + DW'(w_pc[2]);
        r_p <= DW'(w_pp[0]) + DW'(w_pp[1]) + DW'(w_pp[2]);
        r_r <= DW'(w_pr[0]) + DW'(w_pr[1]) + DW'(w_pr[2]);
    end

    // Cramer products
    ptcp_mul #(.AW(DW), .BW(DW)) u_ac (.i_clk, .i_a(r_a), .i_b(r_c), .o_p(w_ac));
    ptcp_mul #(.AW(DW), .BW(DW)) u_bb (.i_clk, .i_a(r_b), .i_b(r_b), .o_p(w_bb));
    ptcp_mul #(.AW(DW), .BW(DW)) u_pc (.i_clk, .i_a(r_p), .i_b(r_c), .o_p(w_pcx));
    ptcp_mul #(.AW(DW), .BW(DW)) u_br (.i_clk, .i_a(r_b), .i_b(r_r), .o_p(w_br));
    ptcp_mul #(.AW(DW), .BW(DW)) u_ar (.i_clk, .i_a(r_a), .i_b(r_r), .o_p(w_ar));
    ptcp_mul #(.AW(DW), .BW(DW)) u_bp (.i_clk, .i_a(r_b), .i_b(r_p), .o_p(w_bp));

    always_ff @(posedge i_clk) begin
        r_det <= TW'(w_ac)  - TW'(w_bb);
        r_nu  <= TW'(w_pcx) - TW'(w_br);
        r_nv  <= TW'(w_ar)  - TW'(w_bp);
    end

    // classify: degenerate, outside or found (bounds inclusive)
    always_comb begin
        w_slack = (TW + 2)'(r_det) - (TW + 2)'(r_nu) - (TW + 2)'(r_nv);
        if (r_det[TW-1] || (r_det == '0)) begin
            w_st = ST_DEGEN;
        end else if (r_nu[TW-1] || r_nv[TW-1] || w_slack[TW+1]) begin
            w_st = ST_OUTSIDE;
        end else begin
            w_st = ST_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st   <= w_st;
        r_detc <= r_det;
        r_nuc  <= r_nu;
        r_nvc  <= r_nv;
    end

    // carry edges and points alongside the arithmetic
    assign w_side = {r_e0[2], r_e0[1], r_e0[0], r_e1[2], r_e1[1], r_e1[0],
                     r_c2[2], r_c2[1], r_c2[0], r_q[2], r_q[1], r_q[0]};

    ptcp_dly #(.W(SW), .N(LS)) u_side (.i_clk, .i_rst_n, .i_d(w_side), .o_d(w_side_d));
    ptcp_dly #(.W(1),  .N(LS)) u_vld  (.i_clk, .i_rst_n, .i_d(r_v0),   .o_d(w_v_d));

    assign o_ctl.valid  = w_v_d;
    assign o_ctl.status = r_st;
    assign o_data       = {r_detc, r_nuc, r_nvc, w_side_d};

endmodule

FILE: src/ptcp_queue.sv
// ----------------------------------------------------------------------------
// ptcp_queue: short queue between front and back
// Stores classified items and presents the oldest one in a register.
// ----------------------------------------------------------------------------
module ptcp_queue import ptcp_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctl         i_ctl,
    input  logic [W-1:0] i_data,
    output t_ctl         o_ctl,
    output logic [W-1:0] o_data
);
    logic [W-1:0]      r_mem_d [QUEUE_DEPTH];
    t_status           r_mem_s [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wptr, r_rptr;
    logic [PTR_BITS:0]   r_cnt;
    logic              w_push, w_pop;
    logic              r_out_v;
    t_status           r_out_s;
    logic [W-1:0]      r_out_d;

    assign w_push = i_ctl.valid;
    assign w_pop  = (r_cnt != '0);

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (w_push) r_wptr <= r_wptr + 1'b1;
            if (w_pop)  r_rptr <= r_rptr + 1'b1;
            r_cnt   <= r_cnt + (PTR_BITS + 1)'(w_push) - (PTR_BITS + 1)'(w_pop);
            r_out_v <= w_pop;
        end
    end

    // storage and registered head
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem_d[r_wptr] <= i_data;
            r_mem_s[r_wptr] <= i_ctl.status;
        end
        r_out_d <= r_mem_d[r_rptr];
        r_out_s <= r_mem_s[r_rptr];
    end

    assign o_ctl.valid  = r_out_v;
    assign o_ctl.status = r_out_s;
    assign o_data       = r_out_d;

endmodule

FILE: src/ptcp_back.sv
// ----------------------------------------------------------------------------
// ptcp_back: carry out the projection
// Weighted edge sums, a restoring floor divider per axis, the nearest point
// and the saturating squared distance.
// ----------------------------------------------------------------------------
module ptcp_back import ptcp_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_ctl                             i_ctl,
    input  logic [item_bits(COORD_BITS)-1:0] i_data,
    output logic                             o_done,
    output logic [STATUS_BITS-1:0]           o_status,
    output logic [2:0][FIELD_BITS-1:0]       o_nearest,
    output logic [DIST_BITS-1:0]             o_dist
);
    localparam int C   = COORD_BITS;
    localparam int EW  = ew_bits(C);
    localparam int TW  = tw_bits(C);
    localparam int QW  = C + 1;
    localparam int NW  = TW + EW + 1;
    localparam int NPW = C + 4;
    localparam int DDW = C + 5;
    localparam int L3  = mul_lat(TW, EW);
    localparam int L4  = mul_lat(DDW, DDW);
    localparam int CW  = $bits(t_ctl);
    localparam int LC  = L3 + QW + L4 + 5;
    localparam int NXW = (NPW > FIELD_BITS) ? NPW : FIELD_BITS;
    localparam int SXW = (2 * DDW > DIST_BITS) ? 2 * DDW : DIST_BITS;

    localparam int OFF_Q   = 0;
    localparam int OFF_C2  = 3 * C;
    localparam int OFF_E1  = 6 * C;
    localparam int OFF_E0  = 6 * C + 3 * EW;
    localparam int OFF_NV  = 6 * C + 6 * EW;
    localparam int OFF_NU  = OFF_NV + TW;
    localparam int OFF_DET = OFF_NU + TW;

    logic signed [TW-1:0] w_nu, w_nv;
    logic signed [EW-1:0] w_e0 [3];
    logic signed [EW-1:0] w_e1 [3];
    logic signed [TW+EW-1:0] w_m0 [3];
    logic signed [TW+EW-1:0] w_m1 [3];
    logic signed [NW-1:0] r_num [3];
    logic [2:0]           r_neg;
    logic [NW-1:0]        r_rem [0:QW][3];
    logic [QW-1:0]        r_quo [0:QW][3];
    logic [TW-1:0]        r_dv  [0:QW];
    logic [TW-1:0]        w_det_d;
    logic [2:0]           w_neg_d;
    logic [6*C-1:0]       w_pts_d;

    logic signed [NPW-1:0] r_np  [3];
    logic signed [C-1:0]   r_qf  [3];
    logic signed [DDW-1:0] r_dd  [3];
    logic signed [NPW-1:0] r_npd [3];
    logic signed [2*DDW-1:0] w_sq [3];
    logic [3*NPW-1:0]      w_np_d;
    logic signed [NPW-1:0] r_nps [3];
    logic [DIST_BITS-1:0]  r_dsum;
    logic [DIST_BITS+1:0]  w_sum;
    logic [DIST_BITS-1:0]  w_sq64 [3];

    logic [CW-1:0] w_ctl_bits;
    t_ctl          w_ctl;

    logic                   r_done;
    logic [STATUS_BITS-1:0] r_status;
    logic [2:0][FIELD_BITS-1:0] r_near;
    logic [DIST_BITS-1:0]   r_dist;

    assign w_nu = signed'(i_data[OFF_NU +: TW]);
    assign w_nv = signed'(i_data[OFF_NV +: TW]);

    // weighted edge sums nu*e0 + nv*e1 per axis
    for (genvar gk = 0; gk < 3; gk++) begin : g_num
        assign w_e0[gk] = signed'(i_data[OFF_E0 + gk*EW +: EW]);
        assign w_e1[gk] = signed'(i_data[OFF_E1 + gk*EW +: EW]);
        ptcp_mul #(.AW(TW), .BW(EW)) u_m0 (.i_clk, .i_a(w_nu), .i_b(w_e0[gk]), .o_p(w_m0[gk]));
        ptcp_mul #(.AW(TW), .BW(EW)) u_m1 (.i_clk, .i_a(w_nv), .i_b(w_e1[gk]), .o_p(w_m1[gk]));
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) r_num[k] <= NW'(w_m0[k]) + NW'(w_m1[k]);
    end

    // split numerator into sign and magnitude, load the divider
    ptcp_dly #(.W(TW), .N(L3 + 1)) u_det (
        .i_clk, .i_rst_n, .i_d(i_data[OFF_DET +: TW]), .o_d(w_det_d)
    );

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_neg[k]    <= r_num[k][NW-1];
            r_rem[0][k] <= r_num[k][NW-1] ? NW'(~r_num[k] + 1'b1) : NW'(r_num[k]);
            r_quo[0][k] <= '0;
        end
        r_dv[0] <= w_det_d;
    end

    // restoring division, one quotient bit per stage
    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int B = QW - 1 - s;
        logic [NW-1:0] w_dsh;

        assign w_dsh = NW'(r_dv[s]) << B;

        always_ff @(posedge i_clk) begin
            r_dv[s+1] <= r_dv[s];
            for (int k = 0; k < 3; k++) begin
                if (r_rem[s][k] >= w_dsh) begin
                    r_rem[s+1][k] <= r_rem[s][k] - w_dsh;
                    r_quo[s+1][k] <= r_quo[s][k] | (QW'(1) << B);
                end else begin
                    r_rem[s+1][k] <= r_rem[s][k];
                    r_quo[s+1][k] <= r_quo[s][k];
                end
            end
        end
    end

    ptcp_dly #(.W(3), .N(QW)) u_neg (.i_clk, .i_rst_n, .i_d(r_neg), .o_d(w_neg_d));
    ptcp_dly #(.W(6 * C), .N(L3 + 2 + QW)) u_pts (
        .i_clk, .i_rst_n, .i_d(i_data[OFF_Q +: 6 * C]), .o_d(w_pts_d)
    );

    // floor the quotient (round a negative one away from zero) and add corner 2
    always_ff @(posedge i_clk) begin
        logic [QW:0]           m;
        logic signed [NPW-1:0] qs;
        for (int k = 0; k < 3; k++) begin
            m  = (QW + 1)'(r_quo[QW][k])
               + (QW + 1)'(w_neg_d[k] && (r_rem[QW][k] != '0));
            qs = signed'(NPW'(m));
            r_np[k] <= NPW'(signed'(w_pts_d[OFF_C2 + k*C +: C])) + (w_neg_d[k] ? -qs : qs);
            r_qf[k] <= signed'(w_pts_d[OFF_Q + k*C +: C]);
        end
    end

    // offset from the query point
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_dd[k]  <= DDW'(r_np[k]) - DDW'(r_qf[k]);
            r_npd[k] <= r_np[k];
        end
    end

    for (genvar gk = 0; gk < 3; gk++) begin : g_sq
        logic signed [SXW-1:0] w_sqx;
        ptcp_mul #(.AW(DDW), .BW(DDW)) u_sq (.i_clk, .i_a(r_dd[gk]), .i_b(r_dd[gk]), .o_p(w_sq[gk]));
        assign w_sqx     = SXW'(w_sq[gk]);
        assign w_sq64[gk] = w_sqx[DIST_BITS-1:0];
    end

    ptcp_dly #(.W(3 * NPW), .N(L4)) u_np (
        .i_clk, .i_rst_n, .i_d({r_npd[2], r_npd[1], r_npd[0]}), .o_d(w_np_d)
    );

    // saturating sum of the squares
    assign w_sum = (DIST_BITS + 2)'(w_sq64[0]) + (DIST_BITS + 2)'(w_sq64[1])
                 + (DIST_BITS + 2)'(w_sq64[2]);

    always_ff @(posedge i_clk) begin
        r_dsum <= (w_sum[DIST_BITS+1:DIST_BITS] != 2'b00) ? '1 : w_sum[DIST_BITS-1:0];
        for (int k = 0; k < 3; k++) r_nps[k] <= signed'(w_np_d[k*NPW +: NPW]);
    end

    // control rides alongside
    ptcp_dly #(.W(CW), .N(LC)) u_ctl (.i_clk, .i_rst_n, .i_d(i_ctl), .o_d(w_ctl_bits));
    assign w_ctl = t_ctl'(w_ctl_bits);

    // drive the result, zero the payload unless found
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= w_ctl.valid;
    end

    always_ff @(posedge i_clk) begin
        logic signed [NXW-1:0] npx;
        r_status <= w_ctl.status;
        for (int k = 0; k < 3; k++) begin
            npx = NXW'(r_nps[k]);
            r_near[k] <= (w_ctl.status == ST_FOUND) ? npx[FIELD_BITS-1:0] : '0;
        end
        r_dist <= (w_ctl.status == ST_FOUND) ? r_dsum : '0;
    end

    assign o_done    = r_done;
    assign o_status  = r_status;
    assign o_nearest = r_near;
    assign o_dist    = r_dist;

endmodule

FILE: src/point_triangle_closest_point_unit.sv
// Path: an item taken on start flows through the front, the queue and the back to o_done;
// at COORD_BITS 32 the back holds a 33-stage restoring divider.
// Throughput: one item per cycle; every stage is a pipeline register.
// busy stays low: the back drains every cycle, so the queue never fills.
// Reset clears the valid flags, queue pointers and delay lines; data registers are not reset.
// ----------------------------------------------------------------------------
// point_triangle_closest_point_unit: closest point on a triangle
// Barycentric projection of a query point onto a triangle in exact fixed
// point, with degenerate and outside reporting.
// ----------------------------------------------------------------------------
module point_triangle_closest_point_unit import ptcp_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [FIELD_BITS-1:0]  i_corner0_x,
    input  logic [FIELD_BITS-1:0]  i_corner0_y,
    input  logic [FIELD_BITS-1:0]  i_corner0_z,
    input  logic [FIELD_BITS-1:0]  i_corner1_x,
    input  logic [FIELD_BITS-1:0]  i_corner1_y,
    input  logic [FIELD_BITS-1:0]  i_corner1_z,
    input  logic [FIELD_BITS-1:0]  i_corner2_x,
    input  logic [FIELD_BITS-1:0]  i_corner2_y,
    input  logic [FIELD_BITS-1:0]  i_corner2_z,
    input  logic [FIELD_BITS-1:0]  i_query_x,
    input  logic [FIELD_BITS-1:0]  i_query_y,
    input  logic [FIELD_BITS-1:0]  i_query_z,
    output logic                   o_done,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [FIELD_BITS-1:0]  o_nearest_x,
    output logic [FIELD_BITS-1:0]  o_nearest_y,
    output logic [FIELD_BITS-1:0]  o_nearest_z,
    output logic [DIST_BITS-1:0]   o_distance_squared
);
    localparam int IW = item_bits(COORD_BITS);

    logic [11:0][FIELD_BITS-1:0] w_fields;
    t_ctl                        w_f_ctl, w_q_ctl;
    logic [IW-1:0]               w_f_data, w_q_data;
    logic [2:0][FIELD_BITS-1:0]  w_near;

    // back side never stalls, so a start is always taken
    assign busy = 1'b0;

    assign w_fields = {i_query_z, i_query_y, i_query_x,
                       i_corner2_z, i_corner2_y, i_corner2_x,
                       i_corner1_z, i_corner1_y, i_corner1_x,
                       i_corner0_z, i_corner0_y, i_corner0_x};

    ptcp_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk, .i_rst_n, .i_take(start & ~busy), .i_fields(w_fields),
        .o_ctl(w_f_ctl), .o_data(w_f_data)
    );

    ptcp_queue #(.W(IW)) u_queue (
        .i_clk, .i_rst_n, .i_ctl(w_f_ctl), .i_data(w_f_data),
        .o_ctl(w_q_ctl), .o_data(w_q_data)
    );

    ptcp_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk, .i_rst_n, .i_ctl(w_q_ctl), .i_data(w_q_data),
        .o_done, .o_status, .o_nearest(w_near), .o_dist(o_distance_squared)
    );

    assign o_nearest_x = w_near[0];
    assign o_nearest_y = w_near[1];
    assign o_nearest_z = w_near[2];

endmodule
